[sv/fmr_pkg.sv]
// ----------------------------------------------------------------------------
// fmr_pkg
// Shared constants, opcodes and controller/datapath interface types for the
// factor model RMSE unit.
// ----------------------------------------------------------------------------
package fmr_pkg;

    // Default sizes of the factor tables.
    localparam int NUM_FEATURES_DEF = 16;
    localparam int MAX_USERS_DEF    = 1024;
    localparam int MAX_ITEMS_DEF    = 1024;

    // Field widths fixed by the interface.
    localparam int OP_W     = 2;
    localparam int INDEX_W  = 10;
    localparam int FEAT_W   = 4;
    localparam int FACTOR_W = 16;
    localparam int RATING_W = 16;
    localparam int COUNT_W  = 24;
    localparam int RES_W    = 32;
    localparam int SUM_W    = 64;

    // Controller step counter: covers the dot product drain, the divider and the root.
    localparam int CNT_W = 7;

    // Input opcodes.
    localparam logic [OP_W-1:0] OP_LOAD_USER = 2'd0;
    localparam logic [OP_W-1:0] OP_LOAD_ITEM = 2'd1;
    localparam logic [OP_W-1:0] OP_SAMPLE    = 2'd2;
    localparam logic [OP_W-1:0] OP_FINISH    = 2'd3;

    // Result kinds.
    localparam logic KIND_SAMPLE = 1'b0;
    localparam logic KIND_FINISH = 1'b1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic start;
        logic load_user;
        logic load_item;
        logic rd_issue;
        logic calc_err;
        logic calc_sq;
        logic div_step;
        logic sqrt_init;
        logic sqrt_step;
        logic out_sample;
        logic out_finish;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_free;
    } t_sts;

endpackage

[sv/fmr_dpath.sv]
// ----------------------------------------------------------------------------
// fmr_dpath
// Factor tables, multiply-accumulate pipeline, error and square stages,
// saturating sum, bit-serial divider, digit-serial square root and the
// output register.
// ----------------------------------------------------------------------------
module fmr_dpath #(
    parameter int NUM_FEATURES = 16,
    parameter int MAX_USERS    = 1024,
    parameter int MAX_ITEMS    = 1024,
    parameter int FIDX_W       = 4
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  fmr_pkg::t_cmd                   i_cmd,
    output fmr_pkg::t_sts                   o_sts,
    input  logic [FIDX_W-1:0]               i_rd_feat,
    input  logic                            i_cfg_we,
    input  logic [fmr_pkg::COUNT_W-1:0]     i_cfg_wdata,
    input  logic [fmr_pkg::INDEX_W-1:0]     i_user_index,
    input  logic [fmr_pkg::INDEX_W-1:0]     i_item_index,
    input  logic [fmr_pkg::FEAT_W-1:0]      i_feature,
    input  logic signed [fmr_pkg::FACTOR_W-1:0] i_factor_value,
    input  logic [fmr_pkg::RATING_W-1:0]    i_rating,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic                            o_result_kind,
    output logic signed [fmr_pkg::RES_W-1:0] o_prediction,
    output logic signed [fmr_pkg::RES_W-1:0] o_pred_error,
    output logic [fmr_pkg::RES_W-1:0]       o_rmse,
    output logic                            o_saturated
);
    import fmr_pkg::*;

    localparam int U_DEPTH = MAX_USERS * NUM_FEATURES;
    localparam int I_DEPTH = MAX_ITEMS * NUM_FEATURES;
    localparam int UAW     = (U_DEPTH > 1) ? $clog2(U_DEPTH) : 1;
    localparam int IAW     = (I_DEPTH > 1) ? $clog2(I_DEPTH) : 1;
    localparam int ACC_W   = 40;

    localparam logic signed [ACC_W-1:0] SAT_HI = 40'sd2147483647;
    localparam logic signed [ACC_W-1:0] SAT_LO = -40'sd2147483648;

    // Factor tables.
    logic signed [FACTOR_W-1:0] r_user_mem [U_DEPTH];
    logic signed [FACTOR_W-1:0] r_item_mem [I_DEPTH];

    // Captured sample fields.
    logic [INDEX_W-1:0]  r_ui;
    logic [INDEX_W-1:0]  r_ii;
    logic [RATING_W-1:0] r_rating;
    logic                r_rows_ok;

    // MAC pipeline.
    logic signed [FACTOR_W-1:0] r_ua;
    logic signed [FACTOR_W-1:0] r_ib;
    logic                       r_rd_vld;
    logic signed [31:0]         r_prod;
    logic                       r_prod_vld;
    logic signed [ACC_W-1:0]    r_acc;

    // Error and square stages.
    logic signed [RES_W-1:0] r_pred;
    logic signed [RES_W-1:0] r_err;
    logic                    r_val_sat;
    logic [SUM_W-1:0]        r_sq;

    // Sum and configuration.
    logic [SUM_W-1:0]   r_sum;
    logic               r_sum_sat;
    logic [COUNT_W-1:0] r_total;

    // Divider and root.
    logic [SUM_W-1:0]   r_quo;
    logic [COUNT_W-1:0] r_rem;
    logic [COUNT_W-1:0] r_den;
    logic [SUM_W-1:0]   r_num;
    logic [SUM_W-1:0]   r_res;
    logic [SUM_W-1:0]   r_bit;

    // Output register.
    logic               r_out_vld;
    logic               r_kind;
    logic signed [RES_W-1:0] r_o_pred;
    logic signed [RES_W-1:0] r_o_err;
    logic [RES_W-1:0]   r_o_rmse;
    logic               r_o_sat;

    logic [31:0]        wr_u_full;
    logic [31:0]        wr_i_full;
    logic [31:0]        rd_u_full;
    logic [31:0]        rd_i_full;
    logic               load_ok_u;
    logic               load_ok_i;
    logic signed [ACC_W-1:0] rnd;
    logic signed [ACC_W-1:0] pred_full;
    logic signed [RES_W-1:0] pred_sat;
    logic signed [ACC_W-1:0] err_full;
    logic signed [RES_W-1:0] err_sat;
    logic               pred_ov;
    logic               err_ov;
    logic signed [SUM_W-1:0] sq_full;
    logic [SUM_W:0]     sum_add;
    logic [SUM_W-1:0]   n_sum;
    logic               n_sum_sat;
    logic [COUNT_W:0]   div_shift;
    logic               div_ge;
    logic [SUM_W-1:0]   sqrt_trial;
    logic               out_free;

    // Table addresses.
    assign wr_u_full = 32'(i_user_index) * 32'(NUM_FEATURES) + 32'(i_feature);
    assign wr_i_full = 32'(i_item_index) * 32'(NUM_FEATURES) + 32'(i_feature);
    assign rd_u_full = 32'(r_ui) * 32'(NUM_FEATURES) + 32'(i_rd_feat);
    assign rd_i_full = 32'(r_ii) * 32'(NUM_FEATURES) + 32'(i_rd_feat);
    assign load_ok_u = (32'(i_user_index) < 32'(MAX_USERS))
                     && (32'(i_feature) < 32'(NUM_FEATURES));
    assign load_ok_i = (32'(i_item_index) < 32'(MAX_ITEMS))
                     && (32'(i_feature) < 32'(NUM_FEATURES));

    // Table writes and registered reads.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_user && load_ok_u) begin
            r_user_mem[wr_u_full[UAW-1:0]] <= i_factor_value;
        end
        if (i_cmd.rd_issue) begin
            r_ua <= r_user_mem[rd_u_full[UAW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item && load_ok_i) begin
            r_item_mem[wr_i_full[IAW-1:0]] <= i_factor_value;
        end
        if (i_cmd.rd_issue) begin
            r_ib <= r_item_mem[rd_i_full[IAW-1:0]];
        end
    end

    // Capture of the sample fields.
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_ui      <= i_user_index;
            r_ii      <= i_item_index;
            r_rating  <= i_rating;
            r_rows_ok <= (32'(i_user_index) < 32'(MAX_USERS))
                      && (32'(i_item_index) < 32'(MAX_ITEMS));
        end
    end

    // Multiply-accumulate pipeline.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_vld   <= 1'b0;
            r_prod_vld <= 1'b0;
        end else begin
            r_rd_vld   <= i_cmd.rd_issue;
            r_prod_vld <= r_rd_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= r_rows_ok ? (32'(r_ua) * 32'(r_ib)) : 32'sd0;
        if (i_cmd.start) begin
            r_acc <= '0;
        end else if (r_prod_vld) begin
            r_acc <= r_acc + {{(ACC_W-32){r_prod[31]}}, r_prod};
        end
    end

    // Rounding, prediction error and clamping.
    always_comb begin
        rnd       = r_acc + 40'sd2048;
        pred_full = rnd >>> 12;
        pred_ov   = (pred_full > SAT_HI) || (pred_full < SAT_LO);
        if (pred_full > SAT_HI) begin
            pred_sat = SAT_HI[RES_W-1:0];
        end else if (pred_full < SAT_LO) begin
            pred_sat = SAT_LO[RES_W-1:0];
        end else begin
            pred_sat = pred_full[RES_W-1:0];
        end
        err_full = {{(ACC_W-RES_W){pred_sat[RES_W-1]}}, pred_sat}
                 - $signed({{(ACC_W-RATING_W){1'b0}}, r_rating});
        err_ov   = (err_full > SAT_HI) || (err_full < SAT_LO);
        if (err_full > SAT_HI) begin
            err_sat = SAT_HI[RES_W-1:0];
        end else if (err_full < SAT_LO) begin
            err_sat = SAT_LO[RES_W-1:0];
        end else begin
            err_sat = err_full[RES_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.calc_err) begin
            r_pred    <= pred_sat;
            r_err     <= err_sat;
            r_val_sat <= pred_ov || err_ov;
        end
    end

    // Squared error.
    assign sq_full = $signed({{RES_W{r_err[RES_W-1]}}, r_err})
                   * $signed({{RES_W{r_err[RES_W-1]}}, r_err});

    always_ff @(posedge i_clk) begin
        if (i_cmd.calc_sq) begin
            r_sq <= sq_full;
        end
    end

    // Saturating sum update.
    always_comb begin
        sum_add   = {1'b0, r_sum} + {1'b0, r_sq};
        n_sum     = sum_add[SUM_W] ? '1 : sum_add[SUM_W-1:0];
        n_sum_sat = r_sum_sat | sum_add[SUM_W];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum     <= '0;
            r_sum_sat <= 1'b0;
            r_total   <= COUNT_W'(1);
        end else begin
            if (i_cfg_we) begin
                r_total <= i_cfg_wdata;
            end
            if (i_cmd.out_sample) begin
                r_sum     <= n_sum;
                r_sum_sat <= n_sum_sat;
            end else if (i_cmd.out_finish) begin
                r_sum     <= '0;
                r_sum_sat <= 1'b0;
            end
        end
    end

    // Restoring divider, one quotient bit a cycle.
    assign div_shift = {r_rem, r_quo[SUM_W-1]};
    assign div_ge    = div_shift >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_quo <= r_sum;
            r_rem <= '0;
            r_den <= (r_total == '0) ? COUNT_W'(1) : r_total;
        end else if (i_cmd.div_step) begin
            r_quo <= {r_quo[SUM_W-2:0], div_ge};
            r_rem <= div_ge ? COUNT_W'(div_shift - {1'b0, r_den})
                            : div_shift[COUNT_W-1:0];
        end
    end

    // Digit-by-digit square root, two radicand bits a cycle.
    assign sqrt_trial = r_res + r_bit;

    always_ff @(posedge i_clk) begin
        if (i_cmd.sqrt_init) begin
            r_num <= r_quo;
            r_res <= '0;
            r_bit <= SUM_W'(1) << (SUM_W - 2);
        end else if (i_cmd.sqrt_step) begin
            if (r_num >= sqrt_trial) begin
                r_num <= r_num - sqrt_trial;
                r_res <= (r_res >> 1) + r_bit;
            end else begin
                r_res <= r_res >> 1;
            end
            r_bit <= r_bit >> 2;
        end
    end

    // Output register.
    assign out_free = !r_out_vld || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_cmd.out_sample || i_cmd.out_finish) begin
            r_out_vld <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_sample) begin
            r_kind   <= KIND_SAMPLE;
            r_o_pred <= r_pred;
            r_o_err  <= r_err;
            r_o_rmse <= '0;
            r_o_sat  <= r_val_sat | n_sum_sat;
        end else if (i_cmd.out_finish) begin
            r_kind   <= KIND_FINISH;
            r_o_pred <= '0;
            r_o_err  <= '0;
            r_o_rmse <= r_res[RES_W-1:0];
            r_o_sat  <= r_sum_sat;
        end
    end

    assign o_sts.out_free = out_free;
    assign o_out_valid    = r_out_vld;
    assign o_result_kind  = r_kind;
    assign o_prediction   = r_o_pred;
    assign o_pred_error   = r_o_err;
    assign o_rmse         = r_o_rmse;
    assign o_saturated    = r_o_sat;

endmodule

[sv/fmr_ctrl.sv]
// ----------------------------------------------------------------------------
// fmr_ctrl
// Sequencer for the factor model RMSE unit: accepts items, walks the
// features of a sample, steps the divider and the root, and posts results.
// ----------------------------------------------------------------------------
module fmr_ctrl #(
    parameter int NUM_FEATURES = 16,
    parameter int FIDX_W       = 4
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic [fmr_pkg::OP_W-1:0]    i_op,
    output fmr_pkg::t_cmd               o_cmd,
    input  fmr_pkg::t_sts               i_sts,
    output logic [FIDX_W-1:0]           o_rd_feat
);
    import fmr_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_MAC   = 3'd1;
    localparam logic [2:0] S_ERR   = 3'd2;
    localparam logic [2:0] S_SQ    = 3'd3;
    localparam logic [2:0] S_DIV   = 3'd4;
    localparam logic [2:0] S_SQINI = 3'd5;
    localparam logic [2:0] S_SQRT  = 3'd6;
    localparam logic [2:0] S_OUT   = 3'd7;

    localparam logic [CNT_W-1:0] MAC_LAST  = CNT_W'(NUM_FEATURES + 1);
    localparam logic [CNT_W-1:0] FEAT_END  = CNT_W'(NUM_FEATURES);
    localparam logic [CNT_W-1:0] DIV_LAST  = CNT_W'(SUM_W - 1);
    localparam logic [CNT_W-1:0] SQRT_LAST = CNT_W'(SUM_W / 2 - 1);

    logic [2:0]       r_state;
    logic [2:0]       n_state;
    logic [CNT_W-1:0] r_cnt;
    logic [CNT_W-1:0] n_cnt;
    logic             r_fin;
    logic             n_fin;
    logic             accept;

    assign accept     = i_in_valid && (r_state == S_IDLE);
    assign o_in_stall = (r_state != S_IDLE);
    assign o_rd_feat  = r_cnt[FIDX_W-1:0];

    // Next state and commands.
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_fin   = r_fin;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                n_cnt = '0;
                if (accept) begin
                    o_cmd.load_user = (i_op == OP_LOAD_USER);
                    o_cmd.load_item = (i_op == OP_LOAD_ITEM);
                    o_cmd.start     = (i_op == OP_SAMPLE) || (i_op == OP_FINISH);
                    if (i_op == OP_SAMPLE) begin
                        n_state = S_MAC;
                        n_fin   = 1'b0;
                    end else if (i_op == OP_FINISH) begin
                        n_state = S_DIV;
                        n_fin   = 1'b1;
                    end
                end
            end
            S_MAC: begin
                o_cmd.rd_issue = (r_cnt < FEAT_END);
                n_cnt          = r_cnt + CNT_W'(1);
                if (r_cnt == MAC_LAST) begin
                    n_state = S_ERR;
                end
            end
            S_ERR: begin
                o_cmd.calc_err = 1'b1;
                n_state        = S_SQ;
            end
            S_SQ: begin
                o_cmd.calc_sq = 1'b1;
                n_state       = S_OUT;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_cnt          = r_cnt + CNT_W'(1);
                if (r_cnt == DIV_LAST) begin
                    n_state = S_SQINI;
                end
            end
            S_SQINI: begin
                o_cmd.sqrt_init = 1'b1;
                n_cnt           = '0;
                n_state         = S_SQRT;
            end
            S_SQRT: begin
                o_cmd.sqrt_step = 1'b1;
                n_cnt           = r_cnt + CNT_W'(1);
                if (r_cnt == SQRT_LAST) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (i_sts.out_free) begin
                    o_cmd.out_sample = !r_fin;
                    o_cmd.out_finish = r_fin;
                    n_state          = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_fin   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_fin   <= n_fin;
        end
    end

endmodule

[sv/factor_model_rmse_unit.sv]
// ----------------------------------------------------------------------------
// factor_model_rmse_unit
// Latent-factor rating predictor with running squared error and RMSE.
//
//   channel  direction  handshake                    payload
//   in       input      i_in_valid / o_in_stall      op, indexes, feature,
//                                                    factor value, rating
//   out      output     o_out_valid / i_out_stall    kind, prediction, error,
//                                                    rmse, saturated
//   cfg      input      i_cfg_we                     total_ratings
//
// A load beat is written without leaving the idle state. A sample runs one
// multiply-accumulate per feature through the two table read ports, then the
// error, square and posting steps. A finish runs the accept step, the bit-serial
// divider, the root's initial and digit steps, and the posting step.
// Reset is synchronous and active low; the tables are not cleared. A result
// waiting under stall holds the sequencer only at its final posting step.
// ----------------------------------------------------------------------------
module factor_model_rmse_unit #(
    parameter int NUM_FEATURES = fmr_pkg::NUM_FEATURES_DEF,
    parameter int MAX_USERS    = fmr_pkg::MAX_USERS_DEF,
    parameter int MAX_ITEMS    = fmr_pkg::MAX_ITEMS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [fmr_pkg::COUNT_W-1:0]     i_cfg_wdata,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [fmr_pkg::OP_W-1:0]        i_op,
    input  logic [fmr_pkg::INDEX_W-1:0]     i_user_index,
    input  logic [fmr_pkg::INDEX_W-1:0]     i_item_index,
    input  logic [fmr_pkg::FEAT_W-1:0]      i_feature,
    input  logic signed [fmr_pkg::FACTOR_W-1:0] i_factor_value,
    input  logic [fmr_pkg::RATING_W-1:0]    i_rating,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic                            o_result_kind,
    output logic signed [fmr_pkg::RES_W-1:0] o_prediction,
    output logic signed [fmr_pkg::RES_W-1:0] o_pred_error,
    output logic [fmr_pkg::RES_W-1:0]       o_rmse,
    output logic                            o_saturated
);
    import fmr_pkg::*;

    localparam int FIDX_W = (NUM_FEATURES > 1) ? $clog2(NUM_FEATURES) : 1;

    t_cmd              cmd;
    t_sts              sts;
    logic [FIDX_W-1:0] rd_feat;

    // Sequencer.
    fmr_ctrl #(
        .NUM_FEATURES (NUM_FEATURES),
        .FIDX_W       (FIDX_W)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_op       (i_op),
        .o_cmd      (cmd),
        .i_sts      (sts),
        .o_rd_feat  (rd_feat)
    );

    // Tables and arithmetic.
    fmr_dpath #(
        .NUM_FEATURES (NUM_FEATURES),
        .MAX_USERS    (MAX_USERS),
        .MAX_ITEMS    (MAX_ITEMS),
        .FIDX_W       (FIDX_W)
    ) u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .i_rd_feat      (rd_feat),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_user_index   (i_user_index),
        .i_item_index   (i_item_index),
        .i_feature      (i_feature),
        .i_factor_value (i_factor_value),
        .i_rating       (i_rating),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_result_kind  (o_result_kind),
        .o_prediction   (o_prediction),
        .o_pred_error   (o_pred_error),
        .o_rmse         (o_rmse),
        .o_saturated    (o_saturated)
    );

endmodule

[bench/factor_model_rmse_unit_test.sv]
// ----------------------------------------------------------------------------
// factor_model_rmse_unit_test
// Self-checking bench for the factor model RMSE unit. Factor rows are loaded
// in full before any sample reads them. Samples and finish beats are predicted
// by an in-bench scoreboard. Several rating counts are used, the extremes
// among them. Both channels idle at random, and one long output hold forces
// the unit to stall its input.
// ----------------------------------------------------------------------------
module factor_model_rmse_unit_test;
    import fmr_pkg::*;

    localparam int NF          = 16;
    localparam int ROWS        = 1024;
    localparam int WATCH_LIMIT = 4000;
    localparam int HOLD_CYCLES = 300;

    typedef struct {
        logic [OP_W-1:0]            op;
        logic [INDEX_W-1:0]         user_index;
        logic [INDEX_W-1:0]         item_index;
        logic [FEAT_W-1:0]          feature;
        logic signed [FACTOR_W-1:0] factor_value;
        logic [RATING_W-1:0]        rating;
    } t_rating_beat;

    typedef struct {
        logic                   kind;
        logic [RES_W-1:0]       prediction;
        logic [RES_W-1:0]       pred_error;
        logic [RES_W-1:0]       rmse;
        logic                   saturated;
    } t_score;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_cfg_we;
    logic [COUNT_W-1:0]     i_cfg_wdata;
    logic                   i_in_valid;
    logic                   o_in_stall;
    logic [OP_W-1:0]        i_op;
    logic [INDEX_W-1:0]     i_user_index;
    logic [INDEX_W-1:0]     i_item_index;
    logic [FEAT_W-1:0]      i_feature;
    logic signed [FACTOR_W-1:0] i_factor_value;
    logic [RATING_W-1:0]    i_rating;
    logic                   o_out_valid;
    logic                   i_out_stall;
    logic                   o_result_kind;
    logic signed [RES_W-1:0] o_prediction;
    logic signed [RES_W-1:0] o_pred_error;
    logic [RES_W-1:0]       o_rmse;
    logic                   o_saturated;

    factor_model_rmse_unit dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_op           (i_op),
        .i_user_index   (i_user_index),
        .i_item_index   (i_item_index),
        .i_feature      (i_feature),
        .i_factor_value (i_factor_value),
        .i_rating       (i_rating),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_result_kind  (o_result_kind),
        .o_prediction   (o_prediction),
        .o_pred_error   (o_pred_error),
        .o_rmse         (o_rmse),
        .o_saturated    (o_saturated)
    );

    // Bench state.
    t_rating_beat          beats_to_send[$];
    t_score                scores_due[$];
    int                    ready_users[$];
    int                    ready_items[$];
    logic signed [15:0]    user_tab [ROWS*NF];
    logic signed [15:0]    item_tab [ROWS*NF];
    longint unsigned       sq_err_sum;
    logic                  sum_sat;
    logic [COUNT_W-1:0]    rating_count;
    int                    errors;
    int                    in_gap;
    int                    out_gap;
    int                    hold_left;
    int                    hold_req;
    int                    hold_done;
    logic                  quiet;
    int                    idle_cycles;
    int                    samples_seen;
    int                    finishes_seen;
    int                    sat_seen;

    // Clock.
    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Integer square root, bit by bit.
    function automatic longint unsigned int_root(longint unsigned n);
        longint unsigned res;
        longint unsigned b;
        res = 0;
        b = 64'd1 << 62;
        while (b > n) b = b >> 2;
        while (b != 0) begin
            if (n >= res + b) begin
                n = n - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    // Scoreboard update for one accepted beat.
    function automatic void score_beat(t_rating_beat b);
        longint          acc;
        longint          pred;
        longint          err;
        longint unsigned sq;
        longint unsigned n;
        logic            sat;
        t_score          s;
        case (b.op)
            OP_LOAD_USER: begin
                user_tab[int'(b.user_index)*NF + int'(b.feature)] = b.factor_value;
            end
            OP_LOAD_ITEM: begin
                item_tab[int'(b.item_index)*NF + int'(b.feature)] = b.factor_value;
            end
            OP_SAMPLE: begin
                acc = 0;
                sat = 1'b0;
                for (int k = 0; k < NF; k++) begin
                    acc += longint'(user_tab[int'(b.user_index)*NF + k]) *
                           longint'(item_tab[int'(b.item_index)*NF + k]);
                end
                pred = (acc + 2048) >>> 12;
                if (pred > 64'sd2147483647) begin
                    pred = 64'sd2147483647;
                    sat = 1'b1;
                end else if (pred < -64'sd2147483648) begin
                    pred = -64'sd2147483648;
                    sat = 1'b1;
                end
                err = pred - longint'(b.rating);
                if (err > 64'sd2147483647) begin
                    err = 64'sd2147483647;
                    sat = 1'b1;
                end else if (err < -64'sd2147483648) begin
                    err = -64'sd2147483648;
                    sat = 1'b1;
                end
                sq = longint'(err * err);
                if (sq_err_sum > ~64'd0 - sq) begin
                    sq_err_sum = ~64'd0;
                    sum_sat = 1'b1;
                end else begin
                    sq_err_sum += sq;
                end
                s.kind = KIND_SAMPLE;
                s.prediction = pred[31:0];
                s.pred_error = err[31:0];
                s.rmse = '0;
                s.saturated = sat | sum_sat;
                scores_due.push_back(s);
            end
            default: begin
                n = (rating_count == 0) ? 64'd1 : longint'(rating_count);
                s.kind = KIND_FINISH;
                s.prediction = '0;
                s.pred_error = '0;
                s.rmse = int_root(sq_err_sum / n);
                s.saturated = sum_sat;
                scores_due.push_back(s);
                sq_err_sum = 0;
                sum_sat = 1'b0;
            end
        endcase
    endfunction

    function automatic void queue_beat(logic [OP_W-1:0] op, int u, int it, int f,
                                       int fv, int r);
        t_rating_beat b;
        b.op = op;
        b.user_index = u[INDEX_W-1:0];
        b.item_index = it[INDEX_W-1:0];
        b.feature = f[FEAT_W-1:0];
        b.factor_value = fv[FACTOR_W-1:0];
        b.rating = r[RATING_W-1:0];
        beats_to_send.push_back(b);
    endfunction

    // Factor value, biased toward the extremes now and then.
    function automatic int pick_factor();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel == 0) return -32768;
        if (sel == 1) return 32767;
        return $urandom_range(0, 65535);
    endfunction

    // Writes a full row so that later samples may read it.
    function automatic void load_row(logic [OP_W-1:0] op, int row, int fixed_val,
                                     logic use_fixed);
        for (int f = 0; f < NF; f++) begin
            queue_beat(op, row, row, f, use_fixed ? fixed_val : pick_factor(),
                       $urandom_range(0, 65535));
        end
        if (op == OP_LOAD_USER) ready_users.push_back(row);
        else ready_items.push_back(row);
    endfunction

    // One random beat: mostly samples on loaded rows, plus loads and finishes.
    function automatic void queue_random();
        int sel;
        int r;
        sel = $urandom_range(0, 99);
        r = ($urandom_range(0, 7) == 0) ? (($urandom_range(0, 1) == 1) ? 65535 : 0)
                                         : $urandom_range(0, 65535);
        if (sel < 20) begin
            queue_beat(OP_LOAD_USER, ready_users[$urandom_range(0, ready_users.size()-1)],
                       $urandom_range(0, 1023), $urandom_range(0, 15), pick_factor(), r);
        end else if (sel < 35) begin
            queue_beat(OP_LOAD_ITEM, $urandom_range(0, 1023),
                       ready_items[$urandom_range(0, ready_items.size()-1)],
                       $urandom_range(0, 15), pick_factor(), r);
        end else if (sel < 37) begin
            if (sel == 35) load_row(OP_LOAD_USER, $urandom_range(0, 1023), 0, 1'b0);
            else load_row(OP_LOAD_ITEM, $urandom_range(0, 1023), 0, 1'b0);
        end else if (sel < 95) begin
            queue_beat(OP_SAMPLE, ready_users[$urandom_range(0, ready_users.size()-1)],
                       ready_items[$urandom_range(0, ready_items.size()-1)],
                       $urandom_range(0, 15), $urandom_range(0, 65535), r);
        end else begin
            queue_beat(OP_FINISH, $urandom_range(0, 1023), $urandom_range(0, 1023),
                       $urandom_range(0, 15), $urandom_range(0, 65535), r);
        end
    endfunction

    // Input driver: holds a stalled beat, otherwise offers the next one.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) score_beat('{i_op, i_user_index, i_item_index,
                                                        i_feature, i_factor_value, i_rating});
            if (!(i_in_valid && o_in_stall)) begin
                if (in_gap > 0) begin
                    in_gap <= in_gap - 1;
                    i_in_valid <= 1'b0;
                end else if (!quiet && $urandom_range(0, 7) == 0) begin
                    in_gap <= $urandom_range(0, 12);
                    i_in_valid <= 1'b0;
                end else if (beats_to_send.size() != 0) begin
                    i_in_valid <= 1'b1;
                    i_op <= beats_to_send[0].op;
                    i_user_index <= beats_to_send[0].user_index;
                    i_item_index <= beats_to_send[0].item_index;
                    i_feature <= beats_to_send[0].feature;
                    i_factor_value <= beats_to_send[0].factor_value;
                    i_rating <= beats_to_send[0].rating;
                    void'(beats_to_send.pop_front());
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Output side: random stall bursts and one long hold on request.
    always @(posedge i_clk) begin
        if (hold_req != hold_done) begin
            hold_done <= hold_req;
            hold_left <= HOLD_CYCLES;
            i_out_stall <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            i_out_stall <= 1'b1;
        end else if (out_gap > 0) begin
            out_gap <= out_gap - 1;
            i_out_stall <= 1'b1;
        end else if (!quiet && $urandom_range(0, 7) == 0) begin
            out_gap <= $urandom_range(0, 12);
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    // Result monitor.
    always @(posedge i_clk) begin
        t_score s;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (scores_due.size() == 0) begin
                $error("unexpected result beat: kind %0d", o_result_kind);
                errors++;
            end else begin
                s = scores_due.pop_front();
                if (o_result_kind == KIND_FINISH) finishes_seen++;
                else samples_seen++;
                if (o_saturated) sat_seen++;
                if (o_result_kind !== s.kind) begin
                    $error("result_kind: expected %0d, actual %0d", s.kind, o_result_kind);
                    errors++;
                end
                if (o_prediction !== s.prediction) begin
                    $error("prediction: expected %0d, actual %0d",
                           $signed(s.prediction), o_prediction);
                    errors++;
                end
                if (o_pred_error !== s.pred_error) begin
                    $error("pred_error: expected %0d, actual %0d",
                           $signed(s.pred_error), o_pred_error);
                    errors++;
                end
                if (o_rmse !== s.rmse) begin
                    $error("rmse: expected %0d, actual %0d", s.rmse, o_rmse);
                    errors++;
                end
                if (o_saturated !== s.saturated) begin
                    $error("saturated: expected %0d, actual %0d", s.saturated, o_saturated);
                    errors++;
                end
            end
        end
    end

    // Watchdog on cycles without any accepted beat.
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCH_LIMIT) begin
            $display("factor_model_rmse_unit test failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic drain();
        while (beats_to_send.size() != 0 || i_in_valid || scores_due.size() != 0)
            @(posedge i_clk);
        repeat (30) @(posedge i_clk);
    endtask

    task automatic set_count(logic [COUNT_W-1:0] value);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= value;
        rating_count = value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic run_phase(int count);
        for (int n = 0; n < count; n++) queue_random();
        queue_beat(OP_FINISH, 0, 0, 0, 0, 0);
    endtask

    // Stimulus sequence.
    initial begin
        logic [COUNT_W-1:0] counts [5];
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_wdata = '0;
        i_in_valid = 1'b0;
        i_op = OP_LOAD_USER;
        i_user_index = '0;
        i_item_index = '0;
        i_feature = '0;
        i_factor_value = '0;
        i_rating = '0;
        i_out_stall = 1'b0;
        errors = 0;
        in_gap = 0;
        out_gap = 0;
        hold_left = 0;
        hold_req = 0;
        hold_done = 0;
        quiet = 1'b0;
        idle_cycles = 0;
        samples_seen = 0;
        finishes_seen = 0;
        sat_seen = 0;
        sq_err_sum = 0;
        sum_sat = 1'b0;
        rating_count = 1;
        for (int k = 0; k < ROWS*NF; k++) begin
            user_tab[k] = '0;
            item_tab[k] = '0;
        end
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: extreme rows, extreme ratings, empty finish.
        queue_beat(OP_FINISH, 0, 0, 0, 0, 0);
        load_row(OP_LOAD_USER, 0, -32768, 1'b1);
        load_row(OP_LOAD_ITEM, 0, -32768, 1'b1);
        load_row(OP_LOAD_USER, 1023, 32767, 1'b1);
        load_row(OP_LOAD_ITEM, 1023, 32767, 1'b1);
        queue_beat(OP_SAMPLE, 0, 0, 0, 0, 0);
        queue_beat(OP_SAMPLE, 0, 1023, 0, 0, 65535);
        queue_beat(OP_SAMPLE, 1023, 1023, 15, -1, 0);
        queue_beat(OP_SAMPLE, 1023, 0, 0, 0, 65535);
        queue_beat(OP_FINISH, 0, 0, 0, 0, 0);
        for (int n = 0; n < 4; n++) begin
            load_row(OP_LOAD_USER, $urandom_range(1, 1022), 0, 1'b0);
            load_row(OP_LOAD_ITEM, $urandom_range(1, 1022), 0, 1'b0);
        end
        drain();

        counts[0] = 1;
        counts[1] = 24'hFFFFFF;
        counts[2] = 0;
        counts[3] = $urandom_range(2, 300);
        counts[4] = $urandom_range(1, 24'hFFFFFF);
        for (int p = 0; p < 5; p++) begin
            set_count(counts[p]);
            if (p == 2) hold_req = hold_req + 1;
            if (p == 4) quiet = 1'b1;
            run_phase(230);
            drain();
        end

        $display("Covered %0d samples and %0d finish beats over five rating counts,",
                 samples_seen, finishes_seen);
        $display("including both count extremes; %0d results flagged saturation.", sat_seen);
        if (errors == 0) begin
            $display("factor_model_rmse_unit test passed");
        end else begin
            $display("factor_model_rmse_unit test failed");
        end
        $finish;
    end

endmodule

[sim.f]
sv/fmr_pkg.sv
sv/fmr_dpath.sv
sv/fmr_ctrl.sv
sv/factor_model_rmse_unit.sv
bench/factor_model_rmse_unit_test.sv
